// ===== hdl/bts_pkg.sv =====
// Shared types and constants of the bilinear texture sampler.
package bts_pkg;

  localparam int CHAN_BITS  = 16;
  localparam int FRAC_BITS  = 16;
  localparam int SIZE_BITS  = 9;
  localparam int POS_BITS   = 8;
  localparam int BASE_BITS  = 17;
  localparam int TEXEL_BITS = 3 * CHAN_BITS;
  localparam int S_DATA_BITS = 136;
  localparam int M_DATA_BITS = TEXEL_BITS;
  localparam int ACC_BITS   = 48;
  localparam int WT_BITS    = 34;

  localparam logic CFG_TEX_WIDTH  = 1'b0;
  localparam logic CFG_TEX_HEIGHT = 1'b1;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic                   wr_ok;
    logic [15:0]            index;
    logic [TEXEL_BITS-1:0]  rgb;
    logic [BASE_BITS-1:0]   base;
    logic [SIZE_BITS-1:0]   width;
    logic [FRAC_BITS-1:0]   w1x;
    logic [FRAC_BITS-1:0]   w1y;
  } entry_t;

endpackage

// ===== hdl/bts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bts_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bts_front.sv =====
// Input stage: takes transactions, wraps and scales coordinates, forms corner and weights.
module bts_front #(
  parameter int TEXEL_COUNT = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [bts_pkg::S_DATA_BITS-1:0]      s_tdata,
  input  logic                                 s_tuser,
  input  logic [bts_pkg::SIZE_BITS-1:0]        size_w,
  input  logic [bts_pkg::SIZE_BITS-1:0]        size_h,
  input  logic                                 full,
  output logic                                 push,
  output bts_pkg::entry_t                      entry
);
  import bts_pkg::*;

  logic                   s1_valid;
  op_t                    s1_op;
  logic [15:0]            s1_index;
  logic [TEXEL_BITS-1:0]  s1_rgb;
  logic [23:0]            s1_scaled_x;
  logic [23:0]            s1_scaled_y;

  logic [FRAC_BITS-1:0]   frac_u;
  logic [FRAC_BITS-1:0]   frac_v;
  logic [POS_BITS-1:0]    wm1;
  logic [POS_BITS-1:0]    hm1;
  logic [POS_BITS-1:0]    hi_x;
  logic [POS_BITS-1:0]    hi_y;
  logic [POS_BITS-1:0]    px;
  logic [POS_BITS-1:0]    py;
  logic [31:0]            idx_wide;

  assign s_tready = !s1_valid || !full;
  assign push     = s1_valid && !full;

  assign frac_u = s_tdata[79:64];
  assign frac_v = s_tdata[128] ? FRAC_BITS'(16'd0 - s_tdata[111:96]) : s_tdata[111:96];
  assign wm1    = POS_BITS'(size_w - SIZE_BITS'(1));
  assign hm1    = POS_BITS'(size_h - SIZE_BITS'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid    <= 1'b1;
      s1_op       <= op_t'(s_tuser);
      s1_index    <= s_tdata[15:0];
      s1_rgb      <= s_tdata[63:16];
      s1_scaled_x <= frac_u * wm1;
      s1_scaled_y <= frac_v * hm1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  assign hi_x     = (size_w >= SIZE_BITS'(2)) ? POS_BITS'(size_w - SIZE_BITS'(2)) : '0;
  assign hi_y     = (size_h >= SIZE_BITS'(2)) ? POS_BITS'(size_h - SIZE_BITS'(2)) : '0;
  assign px       = (s1_scaled_x[23:16] > hi_x) ? hi_x : s1_scaled_x[23:16];
  assign py       = (s1_scaled_y[23:16] > hi_y) ? hi_y : s1_scaled_y[23:16];
  assign idx_wide = 32'(s1_index);

  always_comb begin
    entry.op    = s1_op;
    entry.wr_ok = idx_wide < 32'(TEXEL_COUNT);
    entry.index = s1_index;
    entry.rgb   = s1_rgb;
    entry.base  = BASE_BITS'(py) * BASE_BITS'(size_w) + BASE_BITS'(px);
    entry.width = size_w;
    entry.w1x   = s1_scaled_x[15:0];
    entry.w1y   = s1_scaled_y[15:0];
  end

endmodule

// ===== hdl/bts_queue.sv =====
// Short FIFO between the input stage and the filter engine.
module bts_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bts_pkg::entry_t din,
  input  logic            pop,
  output bts_pkg::entry_t dout,
  output logic            full,
  output logic            empty
);
  import bts_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  entry_t              slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full  = count == CNT_BITS'(DEPTH);
  assign empty = count == '0;
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

// ===== hdl/bts_back.sv =====
// Filter engine: texel store, four-neighbour fetch, weighted blend and result register.
module bts_back #(
  parameter int TEXEL_COUNT = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bts_pkg::entry_t                  entry,
  input  logic                             empty,
  output logic                             pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bts_pkg::M_DATA_BITS-1:0]  m_tdata
);
  import bts_pkg::*;

  localparam int ADDR_BITS = $clog2(TEXEL_COUNT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                 state;
  entry_t                 cur;
  logic [1:0]             k;
  logic                   rd_valid;
  logic [WT_BITS-1:0]     wk;
  logic [ACC_BITS-1:0]    acc [3];
  logic                   out_valid;
  logic [M_DATA_BITS-1:0] out_data;

  logic                   ram_we;
  logic                   ram_re;
  logic [31:0]            waddr_wide;
  logic [31:0]            raddr_wide;
  logic [TEXEL_BITS-1:0]  rdata;
  logic [16:0]            wx;
  logic [16:0]            wy;
  logic [ACC_BITS-1:0]    acc_next [3];
  logic [M_DATA_BITS-1:0] result;

  assign pop        = (state == ST_IDLE) && !empty;
  assign ram_we     = pop && (entry.op == OP_WRITE) && entry.wr_ok;
  assign ram_re     = state == ST_READ;
  assign waddr_wide = 32'(entry.index);
  assign raddr_wide = 32'(cur.base) + 32'(k[0]) + (k[1] ? 32'(cur.width) : 32'd0);
  assign wx = k[0] ? 17'(cur.w1x) : 17'h10000 - 17'(cur.w1x);
  assign wy = k[1] ? 17'(cur.w1y) : 17'h10000 - 17'(cur.w1y);

  bts_ram #(
    .WIDTH (TEXEL_BITS),
    .DEPTH (TEXEL_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_wide[ADDR_BITS-1:0]),
    .wdata (entry.rgb),
    .re    (ram_re),
    .raddr (raddr_wide[ADDR_BITS-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_next[c] = (state == ST_IDLE) ? '0 : acc[c];
      if (rd_valid && wk != '0) begin
        acc_next[c] = acc[c] +
                      ACC_BITS'(rdata[c*CHAN_BITS +: CHAN_BITS]) * ACC_BITS'(wk);
      end
      result[c*CHAN_BITS +: CHAN_BITS] =
        CHAN_BITS'(17'(acc[c][47:32]) + 17'(acc[c][31]));
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      rd_valid <= state == ST_READ;
      for (int c = 0; c < 3; c++) begin
        acc[c] <= acc_next[c];
      end
      if (out_valid && m_tready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop && entry.op == OP_SAMPLE) begin
            cur   <= entry;
            k     <= '0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          wk <= wx * wy;
          k  <= k + 2'd1;
          if (k == 2'd3) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || m_tready) begin
            out_data  <= result;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_rd_in_fetch: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == ST_READ || state == ST_DRAIN))
    else $error("read data arrived outside fetch");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result loaded outside finish");

  a_fetch_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && k == 2'd0) |-> $past(state == ST_IDLE))
    else $error("fetch did not start from idle");

  a_finish_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH |-> !rd_valid)
    else $error("blend not complete at finish");

endmodule

// ===== hdl/bilinear_texture_sampler.sv =====
// Top level of the bilinear texture sampler.
//
// Input stream (s_*): tuser is the operation; a write transaction stores one
// RGB texel at a row-major index, a sample transaction filters the texture at
// (u, v) in signed Q16.16 with repeat wrapping. Output stream (m_*): one
// filtered RGB result per sample, none per write, in input order.
// The cfg port sets tex_width (index 0) and tex_height (index 1); write it only
// while the block is idle.
// The engine finishes one sample before it takes the next entry: the queue pop,
// the four sequential reads of the single-read-port texel store, the blend drain
// and the result load; one write per cycle while the engine is idle. A two-entry
// queue lets input keep flowing while the engine works.
// Reset clears control state and sets both sizes to 1; texel contents are
// undefined until written. When the receiver stalls, the result holds in the
// output register, the engine waits, and input is taken until the queue fills.
module bilinear_texture_sampler #(
  parameter int TEXEL_COUNT = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // texel_index, texel_red, texel_green, texel_blue, u_coord, v_coord, flip_v, zero pad
  input  logic [bts_pkg::S_DATA_BITS-1:0]  s_tdata,
  // op
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_red, out_green, out_blue
  output logic [bts_pkg::M_DATA_BITS-1:0]  m_tdata,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [bts_pkg::SIZE_BITS-1:0]    cfg_data
);
  import bts_pkg::*;

  logic [SIZE_BITS-1:0] tex_width;
  logic [SIZE_BITS-1:0] tex_height;
  logic [SIZE_BITS-1:0] size_w;
  logic [SIZE_BITS-1:0] size_h;
  logic                 push;
  logic                 pop;
  logic                 full;
  logic                 empty;
  entry_t               q_in;
  entry_t               q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= SIZE_BITS'(1);
      tex_height <= SIZE_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEX_WIDTH:  tex_width  <= cfg_data;
        CFG_TEX_HEIGHT: tex_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign size_w = (tex_width == '0) ? SIZE_BITS'(1) :
                  (tex_width > SIZE_BITS'(256)) ? SIZE_BITS'(256) : tex_width;
  assign size_h = (tex_height == '0) ? SIZE_BITS'(1) :
                  (tex_height > SIZE_BITS'(256)) ? SIZE_BITS'(256) : tex_height;

  bts_front #(
    .TEXEL_COUNT (TEXEL_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .size_w   (size_w),
    .size_h   (size_h),
    .full     (full),
    .push     (push),
    .entry    (q_in)
  );

  bts_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_in),
    .pop   (pop),
    .dout  (q_out),
    .full  (full),
    .empty (empty)
  );

  bts_back #(
    .TEXEL_COUNT (TEXEL_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .entry    (q_out),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== tb/tb.sv =====
// Testbench for the bilinear texture sampler: directed and random streams checked against a local predictor.
module tb;
  import bts_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_DATA_BITS-1:0] s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_DATA_BITS-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = 1'b0;
  logic [SIZE_BITS-1:0]   cfg_data = '0;

  bilinear_texture_sampler DUT (.*);

  always #2 clk = ~clk;

  logic [47:0]          texels [0:65535];
  logic [SIZE_BITS-1:0] size_x = 9'd1;
  logic [SIZE_BITS-1:0] size_y = 9'd1;
  logic [47:0]          pending_rgb [$];
  int                   errors = 0;
  bit                   quiet = 1'b0;
  bit                   hold_req = 1'b0;

  task automatic report(input string msg);
    $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  function automatic int eff_size(input logic [SIZE_BITS-1:0] s);
    if (s == 0) return 1;
    if (s > 256) return 256;
    return int'(s);
  endfunction

  function automatic logic [47:0] filter_rgb(input logic [31:0] u, input logic [31:0] v,
                                             input logic flip);
    int unsigned w, h, sx, sy, px, py, base;
    longint unsigned w1x, w1y, w0x, w0y, h0, h1, acc, r;
    logic [15:0] a [4];
    logic [47:0] res;
    w = eff_size(size_x);
    h = eff_size(size_y);
    if (w == 1 && h == 1) return texels[0];
    if (flip) v = -v;
    sx = u[15:0] * (w - 1);
    sy = v[15:0] * (h - 1);
    px = sx >> 16;
    py = sy >> 16;
    if (px > ((w >= 2) ? w - 2 : 0)) px = (w >= 2) ? w - 2 : 0;
    if (py > ((h >= 2) ? h - 2 : 0)) py = (h >= 2) ? h - 2 : 0;
    w1x = sx & 32'hFFFF;
    w1y = sy & 32'hFFFF;
    w0x = 65536 - w1x;
    w0y = 65536 - w1y;
    base = py * w + px;
    a[0] = base[15:0];
    a[1] = 16'(base + 1);
    a[2] = 16'(base + w);
    a[3] = 16'(base + w + 1);
    for (int c = 0; c < 3; c++) begin
      h0 = texels[a[0]][c*16 +: 16] * w0x + texels[a[1]][c*16 +: 16] * w1x;
      h1 = texels[a[2]][c*16 +: 16] * w0x + texels[a[3]][c*16 +: 16] * w1x;
      acc = h0 * w0y + h1 * w1y;
      r = (acc >> 32) + ((acc >> 31) & 1);
      res[c*16 +: 16] = r[15:0];
    end
    return res;
  endfunction

  // Call at a rising edge; returns at the edge that accepts the transaction.
  task automatic send(input op_t op, input logic [15:0] idx, input logic [47:0] rgb,
                      input logic [31:0] u, input logic [31:0] v, input logic flip);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, flip, v, u, rgb, idx};
    do @(posedge clk); while (!s_tready);
    if (op == OP_WRITE) texels[idx] = rgb;
    else pending_rgb.push_back(filter_rgb(u, v, flip));
  endtask

  task automatic pause();
    int r, n;
    r = $urandom_range(0, 99);
    n = quiet ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_texel(input logic [15:0] idx, input logic [47:0] rgb);
    send(OP_WRITE, idx, rgb, $urandom, $urandom, $urandom_range(0, 1));
    pause();
  endtask

  task automatic sample(input logic [31:0] u, input logic [31:0] v, input logic flip);
    send(OP_SAMPLE, 16'($urandom), 48'({$urandom, $urandom}), u, v, flip);
    pause();
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_size(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h);
    drain();
    cfg_we <= 1'b1; cfg_index <= CFG_TEX_WIDTH; cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_TEX_HEIGHT; cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_x = w;
    size_y = h;
  endtask

  function automatic logic [47:0] rand_rgb();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 5))
      0: c[15:0] = 16'h0000;
      1: c[15:0] = 16'hFFFF;
      2: c = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, c[15:0]};
      default: ;
    endcase
    return c;
  endfunction

  task automatic fill_texture();
    int n;
    n = eff_size(size_x) * eff_size(size_y);
    for (int i = 0; i < n; i++) write_texel(16'(i), rand_rgb());
  endtask

  task automatic test_one_texel();
    write_texel(16'd0, 48'hFFFF_0000_FFFF);
    sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    sample(32'h0000_0000, 32'h0000_FFFF, 1'b0);
    write_texel(16'hFFFF, 48'h0000_FFFF_0000);
    write_texel(16'd0, 48'h1234_5678_9ABC);
    sample($urandom, $urandom, 1'b0);
  endtask

  task automatic test_corners();
    set_size(9'd4, 9'd3);
    fill_texture();
    sample(32'h0000_0000, 32'h0000_0000, 1'b0);
    sample(32'h0000_FFFF, 32'h0000_FFFF, 1'b0);
    sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    sample(32'h8000_0000, 32'h8000_0000, 1'b0);
    sample(32'hFFFF_8000, 32'h0000_8000, 1'b1);
    sample(32'h0001_4000, 32'hFFFF_C000, 1'b0);
    sample(32'h0000_5555, 32'h0000_AAAA, 1'b1);
  endtask

  task automatic random_phase(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h,
                              input int items);
    int n;
    set_size(w, h);
    fill_texture();
    n = eff_size(w) * eff_size(h);
    quiet = 1'b0;
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) quiet = 1'b1;
      if (i == items / 2 + 30) quiet = 1'b0;
      if ($urandom_range(0, 9) < 3) begin
        write_texel($urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 65535))
                                              : 16'($urandom_range(0, n - 1)), rand_rgb());
      end else begin
        sample(rand_coord(), rand_coord(), $urandom_range(0, 1));
      end
    end
  endtask

  task automatic test_backpressure();
    set_size(9'd5, 9'd5);
    fill_texture();
    drain();
    hold_req = 1'b1;
    quiet = 1'b1;
    for (int i = 0; i < 24; i++) sample(rand_coord(), rand_coord(), $urandom_range(0, 1));
    quiet = 1'b0;
    drain();
    for (int i = 0; i < 20; i++) sample(rand_coord(), rand_coord(), $urandom_range(0, 1));
  endtask

  // Result sink with random stalls and a forced long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet) begin
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 9) < 7);
      end
    end
  end

  always @(posedge clk) begin
    logic [47:0] exp_rgb;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_rgb.size() == 0) begin
        report($sformatf("unexpected result %h", m_tdata));
      end else begin
        exp_rgb = pending_rgb.pop_front();
        if (m_tdata[15:0] !== exp_rgb[15:0])
          report($sformatf("red %h, want %h", m_tdata[15:0], exp_rgb[15:0]));
        if (m_tdata[31:16] !== exp_rgb[31:16])
          report($sformatf("green %h, want %h", m_tdata[31:16], exp_rgb[31:16]));
        if (m_tdata[47:32] !== exp_rgb[47:32])
          report($sformatf("blue %h, want %h", m_tdata[47:32], exp_rgb[47:32]));
      end
    end
  end

  initial begin
    #20000000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    for (int i = 0; i < 65536; i++) texels[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_one_texel();
    test_corners();
    random_phase(9'd2, 9'd2, 100);
    random_phase(9'd511, 9'd2, 60);
    random_phase(9'd2, 9'd256, 60);
    random_phase(9'd0, 9'd7, 60);
    random_phase(9'd9, 9'd1, 60);
    random_phase(9'd1, 9'd1, 40);
    random_phase(9'd3, 9'd3, 100);
    random_phase(9'd8, 9'd8, 120);
    random_phase(9'd5, 9'd4, 100);
    test_backpressure();
    drain();
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bts_pkg.sv
hdl/bts_ram.sv
hdl/bts_front.sv
hdl/bts_queue.sv
hdl/bts_back.sv
hdl/bilinear_texture_sampler.sv
tb/tb.sv
